// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files that carry concurrent checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/ddo_pkg.sv =====
// Shared types, constants and arithmetic helpers for the odometry block.
// No dependencies.
package ddo_pkg;

    localparam int COUNT_W  = 32;
    localparam int HEAD_W   = 17;
    localparam int SUM_W    = 33;
    localparam int DHEAD_W  = 18;
    localparam int ANGLE_W  = 19;
    localparam int Z_W      = 25;
    localparam int TRIG_W   = 32;
    localparam int POS_W    = 32;
    localparam int DPC_W    = 24;
    localparam int ITER_W   = 5;
    localparam int MAX_STEPS = 24;
    localparam int QDEPTH   = 2;
    localparam int S_DATA_W = 88;
    localparam int M_DATA_W = 96;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DIST_PER_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_X        = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_Y        = 2'd2;

    localparam logic [DPC_W-1:0] DPC_RESET = 24'd11442;

    // Angles: heading change in 1/128 degree, mean angle in 1/256 degree
    localparam logic signed [DHEAD_W-1:0] HALF_TURN_128    = 18'sd23040;
    localparam logic signed [DHEAD_W-1:0] FULL_TURN_128    = 18'sd46080;
    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN_256 = 19'sd23040;
    localparam logic signed [ANGLE_W-1:0] HALF_TURN_256    = 19'sd46080;
    localparam logic signed [ANGLE_W-1:0] FULL_TURN_256    = 19'sd92160;

    // CORDIC start value: reciprocal of the limit gain in Q30
    localparam logic signed [TRIG_W-1:0] TRIG_GAIN = 32'sd652032874;

    // One queued move or reload
    typedef struct packed {
        logic                      reload;
        logic signed [SUM_W-1:0]   count_sum;
        logic signed [DHEAD_W-1:0] dhead;
        logic signed [HEAD_W-1:0]  last_head;
    } cmd_t;

    // Queue status seen by front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // Arctangent of 2^-i in 1/65536 degree
    function automatic logic signed [Z_W-1:0] atan_entry(input logic [ITER_W-1:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            5'd0:  v = 25'sd2949120;
            5'd1:  v = 25'sd1740967;
            5'd2:  v = 25'sd919879;
            5'd3:  v = 25'sd466945;
            5'd4:  v = 25'sd234379;
            5'd5:  v = 25'sd117304;
            5'd6:  v = 25'sd58666;
            5'd7:  v = 25'sd29335;
            5'd8:  v = 25'sd14668;
            5'd9:  v = 25'sd7334;
            5'd10: v = 25'sd3667;
            5'd11: v = 25'sd1833;
            5'd12: v = 25'sd917;
            5'd13: v = 25'sd458;
            5'd14: v = 25'sd229;
            5'd15: v = 25'sd115;
            5'd16: v = 25'sd57;
            5'd17: v = 25'sd29;
            5'd18: v = 25'sd14;
            5'd19: v = 25'sd7;
            5'd20: v = 25'sd4;
            5'd21: v = 25'sd2;
            5'd22: v = 25'sd1;
            default: v = 25'sd0;
        endcase
        return v;
    endfunction

    // Clamp the scaled step to 32 bits
    function automatic logic signed [POS_W-1:0] sat_step(input logic signed [48:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 49'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -49'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    // Clamp an updated position to 32 bits
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [34:0] v);
        logic signed [POS_W-1:0] r;
        if (v > 35'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -35'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

// ===== rtl/differential_drive_odometry.sv =====
// Differential-drive odometry top level: configuration registers, front, queue, back.
// Depends on ddo_pkg, ddo_front, ddo_fifo, ddo_back and assert_macros.svh.
//
//   channel | direction | handshake        | payload
//   s_      | in        | tvalid/tready    | tdata: left, right, heading; tuser: reload
//   m_      | out       | tvalid/tready    | tdata: x_position, y_position, step_distance
//   cfg_    | in        | cfg_we           | cfg_addr selects register, cfg_wdata value
//
// In the back end a move passes through angle reduction, the one-step-per-cycle CORDIC
// rotator and the shared multiplier; a reload loads the start position directly. The
// two-entry queue lets the input take items while the back end works or while a result
// waits. Reset is synchronous, active low, and clears the stored samples, the position
// and both channels; no clearing pass follows.
`include "assert_macros.svh"

module differential_drive_odometry import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // left_count, right_count, heading, zero pad
    input  logic                 s_tuser,   // reload_start
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // x_position, y_position, step_distance
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    logic [DPC_W-1:0]        dpc_reg;
    logic signed [POS_W-1:0] start_x_reg;
    logic signed [POS_W-1:0] start_y_reg;

    logic    q_push;
    logic    q_pop;
    cmd_t    q_cmd;
    cmd_t    q_head;
    q_stat_t q_stat;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dpc_reg     <= DPC_RESET;
            start_x_reg <= '0;
            start_y_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DIST_PER_COUNT: dpc_reg     <= cfg_wdata[DPC_W-1:0];
                CFG_START_X:        start_x_reg <= $signed(cfg_wdata);
                CFG_START_Y:        start_y_reg <= $signed(cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    ddo_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_push   (q_push),
        .q_cmd    (q_cmd),
        .q_stat   (q_stat)
    );

    ddo_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .pop      (q_pop),
        .head_cmd (q_head),
        .stat     (q_stat)
    );

    ddo_back #(
        .NSTEPS (CORDIC_STEPS)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_head         (q_head),
        .q_stat         (q_stat),
        .q_pop          (q_pop),
        .dist_per_count (dpc_reg),
        .start_x        (start_x_reg),
        .start_y        (start_y_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

    // Queue use stays consistent between front and back
    `ASSERT_IMPLIES(a_pop_has_data, aclk, aresetn, q_pop, !q_stat.empty)
    `ASSERT_IMPLIES(a_push_has_room, aclk, aresetn, q_push, !q_stat.full)
    `ASSERT_NEXT(a_push_fills, aclk, aresetn, aresetn && q_push && !q_pop, !q_stat.empty)
    `ASSERT_IMPLIES(a_flags_exclusive, aclk, aresetn, 1'b1, !(q_stat.full && q_stat.empty))

endmodule

// ===== rtl/ddo_front.sv =====
// Front end: takes sensor samples, forms count sum and heading change, queues a command.
// Depends on ddo_pkg.
module ddo_front import ddo_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // left_count, right_count, heading, zero pad
    input  logic                s_tuser,   // reload_start
    output logic                q_push,
    output cmd_t                q_cmd,
    input  q_stat_t             q_stat
);

    logic [COUNT_W-1:0]       last_left_reg;
    logic [COUNT_W-1:0]       last_right_reg;
    logic signed [HEAD_W-1:0] last_head_reg;

    logic [COUNT_W-1:0]       left;
    logic [COUNT_W-1:0]       right;
    logic signed [HEAD_W-1:0] head;
    logic [COUNT_W-1:0]       dl;
    logic [COUNT_W-1:0]       dr;

    assign left  = s_tdata[31:0];
    assign right = s_tdata[63:32];
    assign head  = $signed(s_tdata[80:64]);

    // Accept whenever the queue has room
    assign s_tready = !q_stat.full;
    assign q_push   = s_tvalid && s_tready;

    // Wrapping count differences, summed at full width
    assign dl = left - last_left_reg;
    assign dr = right - last_right_reg;

    always_comb begin
        q_cmd.reload    = s_tuser;
        q_cmd.count_sum = SUM_W'($signed(dl)) + SUM_W'($signed(dr));
        q_cmd.dhead     = DHEAD_W'(head) - DHEAD_W'(last_head_reg);
        q_cmd.last_head = last_head_reg;
    end

    // Record the samples of every transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_left_reg  <= '0;
            last_right_reg <= '0;
            last_head_reg  <= '0;
        end else if (q_push) begin
            last_left_reg  <= left;
            last_right_reg <= right;
            last_head_reg  <= head;
        end
    end

endmodule

// ===== rtl/ddo_fifo.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on ddo_pkg.
module ddo_fifo import ddo_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  cmd_t    push_cmd,
    input  logic    pop,
    output cmd_t    head_cmd,
    output q_stat_t stat
);

    localparam int PTR_W = $clog2(QDEPTH);

    cmd_t             entry_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == (PTR_W+1)'(QDEPTH));
    assign stat.empty = (count_reg == '0);

    // Store on push
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/ddo_back.sv =====
// Back end: angle reduction, iterative CORDIC, shared multiplier, position state, result register.
// Depends on ddo_pkg.
module ddo_back import ddo_pkg::*; #(
    parameter int NSTEPS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cmd_t                    q_head,
    input  q_stat_t                 q_stat,
    output logic                    q_pop,
    input  logic [DPC_W-1:0]        dist_per_count,
    input  logic signed [POS_W-1:0] start_x,
    input  logic signed [POS_W-1:0] start_y,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [M_DATA_W-1:0]     m_tdata
);

    localparam int STEPS_EFF = (NSTEPS > MAX_STEPS) ? MAX_STEPS : NSTEPS;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(STEPS_EFF - 1);

    typedef enum logic [2:0] {
        ST_IDLE, ST_WRAP_D, ST_WRAP_A, ST_ROTATE, ST_MUL_X, ST_MUL_Y, ST_UPD_Y, ST_DONE
    } state_t;

    state_t                     state_reg;
    cmd_t                       cmd_reg;
    logic signed [DHEAD_W-1:0]  d_reg;
    logic signed [ANGLE_W-1:0]  a_reg;
    logic                       neg_reg;
    logic signed [TRIG_W-1:0]   x_reg;
    logic signed [TRIG_W-1:0]   y_reg;
    logic signed [Z_W-1:0]      z_reg;
    logic [ITER_W-1:0]          iter_reg;
    logic signed [41:0]         pp_lo_reg;
    logic signed [41:0]         pp_hi_reg;
    logic signed [POS_W-1:0]    step_reg;
    logic signed [63:0]         prod_reg;
    logic signed [POS_W-1:0]    pos_x_reg;
    logic signed [POS_W-1:0]    pos_y_reg;
    logic                       m_tvalid_reg;
    logic [POS_W-1:0]           out_x_reg;
    logic [POS_W-1:0]           out_y_reg;
    logic [POS_W-1:0]           out_step_reg;

    logic signed [ANGLE_W-1:0]  mean_angle;
    logic signed [ANGLE_W-1:0]  folded;
    logic                       fold_neg;
    logic signed [TRIG_W-1:0]   xs;
    logic signed [TRIG_W-1:0]   ys;
    logic signed [Z_W-1:0]      atan_val;
    logic signed [TRIG_W-1:0]   cos_val;
    logic signed [TRIG_W-1:0]   sin_val;
    logic signed [57:0]         full_prod;
    logic signed [63:0]         rounded;
    logic signed [33:0]         move;
    logic signed [34:0]         pos_sum_x;
    logic signed [34:0]         pos_sum_y;
    logic                       out_load;

    assign q_pop    = (state_reg == ST_IDLE) && !q_stat.empty;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_step_reg, out_y_reg, out_x_reg};

    // Load the result register once it is free
    assign out_load = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // Mean of old and new heading in 1/256 degree
    assign mean_angle = (ANGLE_W'(cmd_reg.last_head) <<< 1) + ANGLE_W'(d_reg);

    // Fold the reduced angle into the right half plane
    always_comb begin
        if (a_reg > QUARTER_TURN_256) begin
            folded   = a_reg - HALF_TURN_256;
            fold_neg = 1'b1;
        end else if (a_reg < -QUARTER_TURN_256) begin
            folded   = a_reg + HALF_TURN_256;
            fold_neg = 1'b1;
        end else begin
            folded   = a_reg;
            fold_neg = 1'b0;
        end
    end

    // One CORDIC micro-rotation
    assign xs       = x_reg >>> iter_reg;
    assign ys       = y_reg >>> iter_reg;
    assign atan_val = atan_entry(iter_reg);
    assign cos_val  = neg_reg ? -x_reg : x_reg;
    assign sin_val  = neg_reg ? -y_reg : y_reg;

    // Step distance from the two partial products, floor shift by 9
    assign full_prod = (58'(pp_hi_reg) <<< 16) + 58'(pp_lo_reg);

    // Rounded move from the registered product
    assign rounded   = prod_reg + 64'sd536870912;
    assign move      = $signed(rounded[63:30]);
    assign pos_sum_x = 35'(pos_x_reg) + 35'(move);
    assign pos_sum_y = 35'(pos_y_reg) + 35'(move);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            pos_x_reg    <= '0;
            pos_y_reg    <= '0;
        end else begin
            // Raise the result on load, drop it once it is taken
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (!q_stat.empty) begin
                        cmd_reg <= q_head;
                        d_reg   <= q_head.dhead;
                        if (q_head.reload) begin
                            pos_x_reg <= start_x;
                            pos_y_reg <= start_y;
                            step_reg  <= '0;
                            state_reg <= ST_DONE;
                        end else begin
                            state_reg <= ST_WRAP_D;
                        end
                    end
                end

                ST_WRAP_D: begin
                    // Split the count sum for two narrow multiplies
                    pp_lo_reg <= $signed({1'b0, cmd_reg.count_sum[15:0]})
                                 * $signed({1'b0, dist_per_count});
                    pp_hi_reg <= $signed(cmd_reg.count_sum[32:16])
                                 * $signed({1'b0, dist_per_count});
                    // Short way round for the heading change
                    if (d_reg >= HALF_TURN_128) begin
                        d_reg <= d_reg - FULL_TURN_128;
                    end else if (d_reg < -HALF_TURN_128) begin
                        d_reg <= d_reg + FULL_TURN_128;
                    end else begin
                        a_reg     <= mean_angle;
                        state_reg <= ST_WRAP_A;
                    end
                end

                ST_WRAP_A: begin
                    step_reg <= sat_step($signed(full_prod[57:9]));
                    // Reduce modulo a full turn, then load the rotator
                    if (a_reg >= HALF_TURN_256) begin
                        a_reg <= a_reg - FULL_TURN_256;
                    end else if (a_reg < -HALF_TURN_256) begin
                        a_reg <= a_reg + FULL_TURN_256;
                    end else begin
                        neg_reg   <= fold_neg;
                        z_reg     <= Z_W'(folded) <<< 8;
                        x_reg     <= TRIG_GAIN;
                        y_reg     <= '0;
                        iter_reg  <= '0;
                        state_reg <= ST_ROTATE;
                    end
                end

                ST_ROTATE: begin
                    if (z_reg >= 0) begin
                        x_reg <= x_reg - ys;
                        y_reg <= y_reg + xs;
                        z_reg <= z_reg - atan_val;
                    end else begin
                        x_reg <= x_reg + ys;
                        y_reg <= y_reg - xs;
                        z_reg <= z_reg + atan_val;
                    end
                    iter_reg <= iter_reg + 1'b1;
                    if (iter_reg == LAST_ITER) begin
                        state_reg <= ST_MUL_X;
                    end
                end

                ST_MUL_X: begin
                    prod_reg  <= step_reg * cos_val;
                    state_reg <= ST_MUL_Y;
                end

                ST_MUL_Y: begin
                    prod_reg  <= step_reg * sin_val;
                    pos_x_reg <= sat_pos(pos_sum_x);
                    state_reg <= ST_UPD_Y;
                end

                ST_UPD_Y: begin
                    pos_y_reg <= sat_pos(pos_sum_y);
                    state_reg <= ST_DONE;
                end

                ST_DONE: begin
                    // Hold until the result register is free
                    if (out_load) begin
                        out_x_reg    <= pos_x_reg;
                        out_y_reg    <= pos_y_reg;
                        out_step_reg <= step_reg;
                        state_reg    <= ST_IDLE;
                    end
                end

                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
